### rtl/prc_pkg.sv
// Package for the pulse rate classifier: payload types, register indexes and constants.
package prc_pkg;

    // Field widths
    localparam int NUM_BITS      = 24;
    localparam int THR_BITS      = 8;
    localparam int RATE_BITS     = 8;
    localparam int CLASS_BITS    = 2;
    localparam int VALUE_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int STEP_BITS     = $clog2(RATE_BITS + 1);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THR  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 2'd3;

    // Reset values of the registers
    localparam logic [NUM_BITS-1:0] RESET_NUMERATOR = 24'd1875000;
    localparam logic [THR_BITS-1:0] RESET_LOW       = 8'd50;
    localparam logic [THR_BITS-1:0] RESET_HIGH      = 8'd100;
    localparam logic [THR_BITS-1:0] RESET_PERIOD    = 8'd122;

    localparam logic [RATE_BITS-1:0] RATE_MAX = 8'hFF;

    // Request kinds
    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Class codes
    localparam logic [CLASS_BITS-1:0] CLASS_SLOW   = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_NORMAL = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_FAST   = 2'd2;

    typedef struct packed {
        logic                  req_type;
        logic [VALUE_BITS-1:0] capture_value;
    } req_t;

    typedef struct packed {
        logic [RATE_BITS-1:0]  rate;
        logic [CLASS_BITS-1:0] rate_class;
        logic                  class_updated;
    } rsp_t;

endpackage

### rtl/pulse_rate_classifier.sv
// Pulse rate classifier: capture pairing, iterative rate divider and tick-driven classifier.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes capture or tick transactions.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result per request:
//   the current rate, the shown class and a flag for a tick that reclassified.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the numerator,
//   the two thresholds and the update period; write it only while idle.
// Sequencing:
//   A tick or the first capture of a pair gives its registered result in the cycle after
//   acceptance, and the next request can be taken in that same cycle if rsp_ready takes it.
//   The second capture of a pair runs a restoring divider: a saturation check, then
//   one quotient bit per cycle on a shared subtractor, then the write state, which
//   waits for a free result slot; no request is taken until it is back in idle.
// Reset: registers go to their reset values, the pairing is cleared, the rate
//   is 0, the class is slow and the tick counter holds 122.
// Stall: one result register sits on the rsp side; a new request is taken
//   while it is full only if rsp_ready takes the waiting result that cycle.
module pulse_rate_classifier #(
    parameter int CAPTURE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  prc_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output prc_pkg::rsp_t                       rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [prc_pkg::NUM_BITS-1:0]        cfg_data
);

    // Dividend 2*N + d and shifted divisor 2*d << RATE_BITS share one width
    localparam int D_BITS = (((prc_pkg::NUM_BITS + 1) > CAPTURE_BITS) ?
                             (prc_pkg::NUM_BITS + 1) : CAPTURE_BITS) + 1;
    localparam int V_BITS = CAPTURE_BITS + prc_pkg::RATE_BITS + 1;
    localparam int W      = (V_BITS > D_BITS) ? V_BITS : D_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    // Configuration
    logic [prc_pkg::NUM_BITS-1:0]   num_reg;
    logic [prc_pkg::THR_BITS-1:0]   low_reg;
    logic [prc_pkg::THR_BITS-1:0]   high_reg;
    logic [prc_pkg::THR_BITS-1:0]   period_reg;

    // Block state
    state_t                          state_reg, state_next;
    logic [CAPTURE_BITS-1:0]         first_reg, first_next;
    logic                            have_first_reg, have_first_next;
    logic [prc_pkg::RATE_BITS-1:0]   rate_reg, rate_next;
    logic [prc_pkg::THR_BITS-1:0]    tick_reg, tick_next;
    logic [prc_pkg::CLASS_BITS-1:0]  class_reg, class_next;

    // Divider
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    div_reg, div_next;
    logic [prc_pkg::STEP_BITS-1:0]   step_reg, step_next;
    logic [prc_pkg::RATE_BITS-1:0]   quo_reg, quo_next;

    // Result register
    logic                            rsp_valid_reg, rsp_valid_next;
    prc_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            req_fire;
    logic                            slot_free;
    logic [CAPTURE_BITS-1:0]         cur;
    logic [CAPTURE_BITS-1:0]         diff;
    logic [W:0]                      sub;
    logic                            ge;

    function automatic logic [prc_pkg::CLASS_BITS-1:0] classify(
        input logic [prc_pkg::RATE_BITS-1:0] r,
        input logic [prc_pkg::THR_BITS-1:0]  lo,
        input logic [prc_pkg::THR_BITS-1:0]  hi
    );
        logic [prc_pkg::CLASS_BITS-1:0] c;
        if (r >= hi)
        begin
            c = prc_pkg::CLASS_FAST;
        end
        else if (r < lo)
        begin
            c = prc_pkg::CLASS_SLOW;
        end
        else
        begin
            c = prc_pkg::CLASS_NORMAL;
        end
        return c;
    endfunction

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Capture difference, modulo the capture width
    assign cur  = CAPTURE_BITS'(req_data.capture_value);
    assign diff = cur - first_reg;

    // Shared subtractor of the divider
    assign sub = {1'b0, rem_reg} - {1'b0, div_reg};
    assign ge  = !sub[W];

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        rate_next       = rate_reg;
        tick_next       = tick_reg;
        class_next      = class_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        quo_next        = quo_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_data.req_type == prc_pkg::REQ_TICK)
                    begin
                        rsp_next.class_updated = 1'b0;
                        if (tick_reg == '0)
                        begin
                            class_next             = classify(rate_reg, low_reg, high_reg);
                            tick_next              = period_reg - 1'b1;
                            rsp_next.class_updated = 1'b1;
                        end
                        else
                        begin
                            tick_next = tick_reg - 1'b1;
                        end
                        rsp_next.rate       = rate_reg;
                        rsp_next.rate_class = class_next;
                        rsp_valid_next      = 1'b1;
                    end
                    else if (!have_first_reg)
                    begin
                        first_next             = cur;
                        have_first_next        = 1'b1;
                        rsp_next.rate          = rate_reg;
                        rsp_next.rate_class    = class_reg;
                        rsp_next.class_updated = 1'b0;
                        rsp_valid_next         = 1'b1;
                    end
                    else
                    begin
                        // Load dividend 2N + d and divisor 2d << RATE_BITS
                        first_next      = '0;
                        have_first_next = 1'b0;
                        rem_next        = (W'(num_reg) << 1) + W'(diff);
                        div_next        = W'(diff) << (prc_pkg::RATE_BITS + 1);
                        step_next       = prc_pkg::STEP_BITS'(prc_pkg::RATE_BITS);
                        quo_next        = '0;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                div_next = div_reg >> 1;
                if (step_reg == prc_pkg::STEP_BITS'(prc_pkg::RATE_BITS))
                begin
                    // Quotient of 256 or more saturates (also covers zero difference)
                    if (ge)
                    begin
                        quo_next   = prc_pkg::RATE_MAX;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
                else
                begin
                    if (ge)
                    begin
                        rem_next = sub[W-1:0];
                    end
                    quo_next = {quo_reg[prc_pkg::RATE_BITS-2:0], ge};
                    if (step_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        step_next = step_reg - 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    rate_next              = quo_reg;
                    rsp_next.rate          = quo_reg;
                    rsp_next.rate_class    = class_reg;
                    rsp_next.class_updated = 1'b0;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= prc_pkg::RESET_NUMERATOR;
            low_reg    <= prc_pkg::RESET_LOW;
            high_reg   <= prc_pkg::RESET_HIGH;
            period_reg <= prc_pkg::RESET_PERIOD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                prc_pkg::REG_NUMERATOR: num_reg    <= cfg_data;
                prc_pkg::REG_LOW_THR:   low_reg    <= cfg_data[prc_pkg::THR_BITS-1:0];
                prc_pkg::REG_HIGH_THR:  high_reg   <= cfg_data[prc_pkg::THR_BITS-1:0];
                prc_pkg::REG_PERIOD:    period_reg <= cfg_data[prc_pkg::THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            rate_reg       <= '0;
            tick_reg       <= prc_pkg::RESET_PERIOD;
            class_reg      <= prc_pkg::CLASS_SLOW;
            step_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            rate_reg       <= rate_next;
            tick_reg       <= tick_next;
            class_reg      <= class_next;
            step_reg       <= step_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
        rsp_reg <= rsp_next;
    end

endmodule

### sim/pulse_rate_classifier_test.sv
// Self-checking testbench for the pulse rate classifier: directed table, then random phases.
`timescale 1ns / 100ps

module pulse_rate_classifier_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic [1:0] {ROW_CAPTURE, ROW_TICK, ROW_WRITE} row_kind_t;

    // One line of the directed table; want is used only when typed is set
    typedef struct {
        row_kind_t                          kind;
        logic [prc_pkg::CFG_IDX_BITS-1:0]   idx;
        logic [prc_pkg::NUM_BITS-1:0]       value;
        bit                                 typed;
        prc_pkg::rsp_t                      want;
    } row_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_ready;
    prc_pkg::req_t                      req_data  = '0;
    logic                               rsp_valid;
    logic                               rsp_ready = 1'b0;
    prc_pkg::rsp_t                      rsp_data;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [prc_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [prc_pkg::NUM_BITS-1:0]       cfg_data  = '0;

    // Meter copy: configuration and state as the block should hold them
    logic [prc_pkg::NUM_BITS-1:0]   num_cfg      = prc_pkg::RESET_NUMERATOR;
    logic [prc_pkg::THR_BITS-1:0]   low_cfg      = prc_pkg::RESET_LOW;
    logic [prc_pkg::THR_BITS-1:0]   high_cfg     = prc_pkg::RESET_HIGH;
    logic [prc_pkg::THR_BITS-1:0]   period_cfg   = prc_pkg::RESET_PERIOD;
    logic [prc_pkg::VALUE_BITS-1:0] held_capture = '0;
    logic                           holding      = 1'b0;
    logic [prc_pkg::RATE_BITS-1:0]  cur_rate     = '0;
    logic [prc_pkg::THR_BITS-1:0]   tick_left    = prc_pkg::RESET_PERIOD;
    logic [prc_pkg::CLASS_BITS-1:0] cur_class    = prc_pkg::CLASS_SLOW;

    prc_pkg::rsp_t rate_reports_due[$];
    row_t          steps[$];
    prc_pkg::rsp_t want_rsp;

    int  mismatches    = 0;
    int  cycles        = 0;
    int  captures_sent = 0;
    int  ticks_sent    = 0;
    int  settings_used = 0;
    int  updates_seen  = 0;
    int  class_seen[3] = '{0, 0, 0};
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;

    pulse_rate_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Rounded quotient of the numerator over the capture span, saturated
    function automatic logic [prc_pkg::RATE_BITS-1:0] rate_from_span(
        logic [prc_pkg::VALUE_BITS-1:0] span
    );
        longint unsigned quot;
        if (span == 0)
            return prc_pkg::RATE_MAX;
        quot = (2 * longint'(num_cfg) + longint'(span)) / (2 * longint'(span));
        return (quot > prc_pkg::RATE_MAX) ? prc_pkg::RATE_MAX : quot[prc_pkg::RATE_BITS-1:0];
    endfunction

    // Fast is tested ahead of slow, so crossed thresholds favor fast
    function automatic logic [prc_pkg::CLASS_BITS-1:0] class_of(
        logic [prc_pkg::RATE_BITS-1:0] r
    );
        if (r >= high_cfg)
            return prc_pkg::CLASS_FAST;
        if (r < low_cfg)
            return prc_pkg::CLASS_SLOW;
        return prc_pkg::CLASS_NORMAL;
    endfunction

    // Advance the meter copy by one request and return the report it gives
    function automatic prc_pkg::rsp_t next_report(prc_pkg::req_t item);
        prc_pkg::rsp_t res;
        res.class_updated = 1'b0;
        if (item.req_type == prc_pkg::REQ_CAPTURE)
        begin
            if (!holding)
            begin
                held_capture = item.capture_value;
                holding      = 1'b1;
            end
            else
            begin
                cur_rate     = rate_from_span(item.capture_value - held_capture);
                held_capture = '0;
                holding      = 1'b0;
            end
        end
        else
        begin
            if (tick_left == 0)
            begin
                cur_class         = class_of(cur_rate);
                res.class_updated = 1'b1;
                tick_left         = period_cfg;
            end
            tick_left = tick_left - 1'b1;
        end
        res.rate       = cur_rate;
        res.rate_class = cur_class;
        return res;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_row(row_kind_t kind, logic [prc_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [prc_pkg::NUM_BITS-1:0] value, bit typed,
                                    logic [prc_pkg::RATE_BITS-1:0] r,
                                    logic [prc_pkg::CLASS_BITS-1:0] c,
                                    logic u);
        row_t s;
        s.kind  = kind;
        s.idx   = idx;
        s.value = value;
        s.typed = typed;
        s.want  = '{rate: r, rate_class: c, class_updated: u};
        steps.push_back(s);
    endfunction

    // One request transaction; valid stays up for a back-to-back follower
    task automatic send_item(prc_pkg::req_t item, bit typed, prc_pkg::rsp_t want);
        prc_pkg::rsp_t predicted;
        int            gap;
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = next_report(item);
        rate_reports_due.push_back(typed ? want : predicted);
        if (item.req_type == prc_pkg::REQ_TICK)
            ticks_sent++;
        else
            captures_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_kind(logic kind, logic [prc_pkg::VALUE_BITS-1:0] value);
        prc_pkg::req_t item;
        item.req_type      = kind;
        item.capture_value = value;
        send_item(item, 1'b0, '0);
    endtask

    // Stop sending and wait until every report has come back
    task automatic drain_reports();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (rate_reports_due.size() != 0);
    endtask

    // Register write transaction; the caller lowers cfg_valid after the last one
    task automatic write_reg(logic [prc_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [prc_pkg::NUM_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            prc_pkg::REG_NUMERATOR: num_cfg    = data;
            prc_pkg::REG_LOW_THR:   low_cfg    = data[prc_pkg::THR_BITS-1:0];
            prc_pkg::REG_HIGH_THR:  high_cfg   = data[prc_pkg::THR_BITS-1:0];
            prc_pkg::REG_PERIOD:    period_cfg = data[prc_pkg::THR_BITS-1:0];
            default: ;
        endcase
    endtask

    // Load a full setting while idle; upper bits of the 8-bit writes carry junk
    task automatic program_regs(logic [prc_pkg::NUM_BITS-1:0] num,
                                logic [prc_pkg::THR_BITS-1:0] lo,
                                logic [prc_pkg::THR_BITS-1:0] hi,
                                logic [prc_pkg::THR_BITS-1:0] per);
        logic [15:0] junk;
        drain_reports();
        write_reg(prc_pkg::REG_NUMERATOR, num);
        junk = 16'($urandom);
        write_reg(prc_pkg::REG_LOW_THR, {junk, lo});
        junk = 16'($urandom);
        write_reg(prc_pkg::REG_HIGH_THR, {junk, hi});
        junk = 16'($urandom);
        write_reg(prc_pkg::REG_PERIOD, {junk, per});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Result side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= pick_gap();
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected report
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rate_reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: rate %0d class %0d updated %0b",
                             rsp_data.rate, rsp_data.rate_class, rsp_data.class_updated);
            end
            else
            begin
                want_rsp = rate_reports_due.pop_front();
                if (rsp_data.rate !== want_rsp.rate
                        || rsp_data.rate_class !== want_rsp.rate_class
                        || rsp_data.class_updated !== want_rsp.class_updated)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch at cycle %0d: rate %0d/%0d class %0d/%0d %s %0b/%0b",
                                 cycles, rsp_data.rate, want_rsp.rate,
                                 rsp_data.rate_class, want_rsp.rate_class,
                                 "updated", rsp_data.class_updated,
                                 want_rsp.class_updated);
                end
                if (want_rsp.class_updated)
                    updates_seen++;
                if (want_rsp.rate_class <= prc_pkg::CLASS_FAST)
                    class_seen[want_rsp.rate_class]++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycles, rate_reports_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        prc_pkg::req_t                  item;
        int                             phase;
        int                             phase_items;
        int                             tick_pct;
        int                             stop_at;
        int                             roll;
        int unsigned                    quot;
        logic [prc_pkg::VALUE_BITS-1:0] first_value;
        logic [prc_pkg::VALUE_BITS-1:0] span;
        logic [prc_pkg::THR_BITS-1:0]   lo;
        logic [prc_pkg::THR_BITS-1:0]   hi;
        logic [prc_pkg::THR_BITS-1:0]   per;
        logic [prc_pkg::NUM_BITS-1:0]   num;

        // Directed table, reset settings in force at the start
        // tick right after reset: value ignored, nothing measured yet
        add_row(ROW_TICK,    prc_pkg::REG_NUMERATOR, 24'h00FFFF, 1, 8'd0,
                prc_pkg::CLASS_SLOW, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000000, 1, 8'd0,
                prc_pkg::CLASS_SLOW, 1'b0);
        // same timer value twice: zero span gives full scale
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000000, 1, prc_pkg::RATE_MAX,
                prc_pkg::CLASS_SLOW, 1'b0);
        // span of one across the timer wrap saturates
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h00FFFF, 1, prc_pkg::RATE_MAX,
                prc_pkg::CLASS_SLOW, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000000, 1, prc_pkg::RATE_MAX,
                prc_pkg::CLASS_SLOW, 1'b0);
        // widest span
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000000, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h00FFFF, 0, '0, '0, 1'b0);
        // half-way quotients round up; a tick inside the pair keeps the pairing
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'd100,    0, '0, '0, 1'b0);
        add_row(ROW_TICK,    prc_pkg::REG_NUMERATOR, 24'h005555, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'd10100,  0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'd1000,   0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'd31000,  0, '0, '0, 1'b0);
        // zero numerator gives a zero rate
        add_row(ROW_WRITE,   prc_pkg::REG_NUMERATOR, 24'd0,      0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h008000, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h008007, 1, 8'd0,
                prc_pkg::CLASS_SLOW, 1'b0);
        // largest numerator over the widest span still saturates
        add_row(ROW_WRITE,   prc_pkg::REG_NUMERATOR, 24'hFFFFFF, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000001, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h000000, 1, prc_pkg::RATE_MAX,
                prc_pkg::CLASS_SLOW, 1'b0);
        // 8-bit registers keep only their low byte; zero period, thresholds at 0 and 255
        add_row(ROW_WRITE,   prc_pkg::REG_LOW_THR,   24'hFFFF00, 0, '0, '0, 1'b0);
        add_row(ROW_WRITE,   prc_pkg::REG_HIGH_THR,  24'h0000FF, 0, '0, '0, 1'b0);
        add_row(ROW_WRITE,   prc_pkg::REG_PERIOD,    24'hABCD00, 0, '0, '0, 1'b0);
        add_row(ROW_TICK,    prc_pkg::REG_NUMERATOR, 24'h000000, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h007FFF, 0, '0, '0, 1'b0);
        add_row(ROW_CAPTURE, prc_pkg::REG_NUMERATOR, 24'h00FFFE, 0, '0, '0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; consecutive writes share one valid window
        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_WRITE)
            begin
                if (i == 0 || steps[i-1].kind != ROW_WRITE)
                    drain_reports();
                write_reg(steps[i].idx, steps[i].value);
            end
            else
            begin
                if (i != 0 && steps[i-1].kind == ROW_WRITE)
                    cfg_valid <= 1'b0;
                item.req_type      = (steps[i].kind == ROW_TICK) ?
                                     prc_pkg::REQ_TICK : prc_pkg::REQ_CAPTURE;
                item.capture_value = steps[i].value[prc_pkg::VALUE_BITS-1:0];
                send_item(item, steps[i].typed, steps[i].want);
            end
        end

        // Random phases, one register setting each
        for (phase = 0; phase < 10; phase++)
        begin
            num = 24'($urandom_range(1000, 24'hFFFFFF));
            lo  = 8'($urandom_range(0, 200));
            hi  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(lo + $urandom_range(0, 55));
            per = 8'($urandom_range(1, 6));
            phase_items = 90;
            tick_pct    = 45;
            case (phase)
                0:
                begin
                    num = prc_pkg::RESET_NUMERATOR;
                    lo  = prc_pkg::RESET_LOW;
                    hi  = prc_pkg::RESET_HIGH;
                    per = 8'd3;
                    phase_items = 150;
                    tick_pct    = 90;
                end
                1:
                begin
                    num = 24'hFFFFFF; lo = 8'd0; hi = 8'd255; per = 8'd1;
                end
                2:
                begin
                    num = 24'd1; lo = 8'd255; hi = 8'd0; per = 8'd2;
                end
                8: per = 8'd0;
                9:
                begin
                    per         = 8'd255;
                    phase_items = 300;
                    tick_pct    = 90;
                end
                default: ;
            endcase
            program_regs(num, lo, hi, per);
            no_idle = (phase == 3 || phase == 6);

            stop_at = captures_sent + ticks_sent + phase_items;
            while (captures_sent + ticks_sent < stop_at)
            begin
                roll = $urandom_range(0, 99);
                if (roll < tick_pct)
                begin
                    send_kind(prc_pkg::REQ_TICK, 16'($urandom));
                end
                else if (roll < 95)
                begin
                    // well-formed pair, span aimed at a spread of rates
                    case ($urandom_range(0, 9))
                        0: span = '0;
                        1: span = 16'($urandom);
                        2: span = 16'($urandom_range(1, 16));
                        default:
                        begin
                            quot = num_cfg / $urandom_range(1, 300);
                            if (quot > 65535)
                                quot = 65535;
                            if (quot == 0)
                                quot = 1;
                            quot = quot + $urandom_range(0, 2);
                            span = quot[prc_pkg::VALUE_BITS-1:0] - 1'b1;
                        end
                    endcase
                    first_value = 16'($urandom);
                    send_kind(prc_pkg::REQ_CAPTURE, first_value);
                    if ($urandom_range(0, 3) == 0)
                        send_kind(prc_pkg::REQ_TICK, 16'($urandom));
                    send_kind(prc_pkg::REQ_CAPTURE, first_value + span);
                end
                else
                begin
                    // lone capture shifts the pairing
                    send_kind(prc_pkg::REQ_CAPTURE, 16'($urandom));
                end
                if ($urandom_range(0, 99) == 0)
                    drain_reports();
            end
        end
        no_idle = 1'b0;

        drain_reports();
        repeat (32) @(posedge clk);

        $display("sent %0d captures and %0d ticks under %0d register settings",
                 captures_sent, ticks_sent, settings_used);
        $display("%0d reclassifications; reports slow/normal/fast %0d/%0d/%0d; %0d mismatches",
                 updates_seen, class_seen[prc_pkg::CLASS_SLOW],
                 class_seen[prc_pkg::CLASS_NORMAL],
                 class_seen[prc_pkg::CLASS_FAST], mismatches);
        if (mismatches == 0 && rate_reports_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
